// ===== rtl/mds_pkg.sv =====
// Motor drive supervisor package: shared types, state codes, frame ids and
// fixed-point constants. No dependencies.
package mds_pkg;

    // drive states; the LED color code uses the same values
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_OVER = 2'd2;

    // CAN identifiers
    localparam logic [10:0] BRAKE_ID    = 11'd1;
    localparam logic [10:0] BATTERY_ID  = 11'd2;
    localparam logic [10:0] STEERING_ID = 11'd3;
    localparam logic [10:0] ENCODER_ID  = 11'd4;

    // configuration register indexes
    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_CURRENT     = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PWM_TOP         = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_BASE       = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_SLOPE      = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWPASS_WEIGHT  = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RPM_WORD_SEL    = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_SCALE   = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_RESTART_MASK    = 4'd7;

    // configuration reset values
    localparam logic [15:0] RST_MAX_CURRENT     = 16'd8000;
    localparam logic [15:0] RST_PWM_TOP         = 16'h0319;
    localparam logic [9:0]  RST_DUTY_BASE       = 10'd100;
    localparam logic [15:0] RST_DUTY_SLOPE      = 16'd256;
    localparam logic [8:0]  RST_LOWPASS_WEIGHT  = 9'd26;
    localparam logic [1:0]  RST_RPM_WORD_SEL    = 2'd0;
    localparam logic [7:0]  RST_CURRENT_SCALE   = 8'd32;
    localparam logic [7:0]  RST_RESTART_MASK    = 8'd1;

    // control rule constants
    localparam logic [10:0] ADC_MIDPOINT = 11'd512;
    localparam logic [8:0]  WEIGHT_FULL  = 9'd256;
    localparam logic [7:0]  DEADMAN_MIN  = 8'd50;
    localparam logic [7:0]  BATT_START   = 8'h02;

    // duty = floor((throttle * ceil256 >> 8) / 100); reciprocal 2^30/100 rounded up,
    // exact for quotients below QUOT_LIMIT (anything larger saturates anyway)
    localparam logic [32:0] QUOT_LIMIT  = 33'd6553600;
    localparam logic [23:0] RECIP_K     = 24'd10737419;

    typedef struct packed {
        logic [15:0] max_current;
        logic [15:0] pwm_top;
        logic [9:0]  duty_base;
        logic [15:0] duty_slope;
        logic [8:0]  lowpass_weight;
        logic [1:0]  rpm_word_sel;
        logic [7:0]  current_scale;
        logic [7:0]  restart_mask;
    } cfg_t;

    typedef struct packed {
        logic accept;
        logic calc1;
        logic calc2;
        logic calc3;
        logic calc4;
        logic step;
    } cmd_t;

endpackage

// ===== rtl/mds_ctrl.sv =====
// Motor drive supervisor controller: sequences one request through the
// datapath phases and owns both handshakes. Depends on mds_pkg.
module mds_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    output mds_pkg::cmd_t cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CALC1 = 3'd1;
    localparam logic [2:0] S_CALC2 = 3'd2;
    localparam logic [2:0] S_CALC3 = 3'd3;
    localparam logic [2:0] S_CALC4 = 3'd4;
    localparam logic [2:0] S_STEP  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       step_fire;

    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = m_valid_reg;
    assign step_fire = (state_reg == S_STEP) && (!m_valid_reg || m_ready);

    always_comb begin
        cmd        = '0;
        cmd.accept = s_valid && s_ready;
        cmd.calc1  = (state_reg == S_CALC1);
        cmd.calc2  = (state_reg == S_CALC2);
        cmd.calc3  = (state_reg == S_CALC3);
        cmd.calc4  = (state_reg == S_CALC4);
        cmd.step   = step_fire;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (s_valid) state_next = S_CALC1;
            S_CALC1: state_next = S_CALC2;
            S_CALC2: state_next = S_CALC3;
            S_CALC3: state_next = S_CALC4;
            S_CALC4: state_next = S_STEP;
            S_STEP:  if (step_fire) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        if (step_fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ===== rtl/mds_datapath.sv =====
// Motor drive supervisor datapath: command latches, current filter, duty
// multiply chain, drive state rules and result register. Depends on mds_pkg.
module mds_datapath (
    input  logic          aclk,
    input  logic          aresetn,
    input  mds_pkg::cfg_t cfg,
    input  mds_pkg::cmd_t cmd,
    input  logic          s_func,
    input  logic [10:0]   s_frame_id,
    input  logic [7:0]    s_data_byte0,
    input  logic [7:0]    s_data_byte1,
    input  logic [7:0]    s_data_byte2,
    input  logic [7:0]    s_data_byte3,
    input  logic [7:0]    s_data_byte4,
    input  logic [7:0]    s_data_byte5,
    input  logic [7:0]    s_data_byte6,
    input  logic [7:0]    s_data_byte7,
    input  logic [9:0]    s_adc_sample,
    output logic [1:0]    m_state_code,
    output logic [15:0]   m_duty,
    output logic          m_dcdc_on,
    output logic [1:0]    m_led_color,
    output logic          m_frame_due,
    output logic [1:0]    m_frame_status,
    output logic [7:0]    m_frame_throttle,
    output logic [15:0]   m_frame_current,
    output logic [15:0]   m_frame_duty,
    output logic [15:0]   m_frame_rpm
);

    // control state
    logic [1:0]  drive_reg, drive_next;
    logic [7:0]  brake_reg, battery_reg, throttle_reg, restart_reg, deadman_reg;
    logic [15:0] rpm_reg, fc_reg, duty_reg, duty_next;
    logic        conv_reg, conv_next;

    // item and pipeline registers
    logic        tick_reg;
    logic [9:0]  adc_reg;
    logic [15:0] ma_reg;
    logic [31:0] prod_reg;
    logic [24:0] pnew_reg;
    logic [32:0] ceil_reg;
    logic [32:0] quot_reg;
    logic        big_reg;
    logic [15:0] d_reg;

    // result register
    logic [1:0]  out_state_reg, out_fstatus_reg;
    logic [15:0] out_duty_reg, out_fcur_reg, out_fduty_reg, out_frpm_reg;
    logic        out_conv_reg, out_due_reg;
    logic [7:0]  out_fthr_reg;

    logic [9:0]  offset;
    logic [17:0] ma_full;
    logic [8:0]  w_eff, w_inv;
    logic [24:0] fsum;
    logic [40:0] tprod;
    logic [46:0] recip;
    logic [15:0] rpm_word;
    logic [15:0] run_duty;

    always_comb begin
        case (cfg.rpm_word_sel)
            2'd0:    rpm_word = {s_data_byte1, s_data_byte0};
            2'd1:    rpm_word = {s_data_byte3, s_data_byte2};
            2'd2:    rpm_word = {s_data_byte5, s_data_byte4};
            2'd3:    rpm_word = {s_data_byte7, s_data_byte6};
            default: rpm_word = {s_data_byte1, s_data_byte0};
        endcase
    end

    assign offset  = ({1'b0, adc_reg} <= mds_pkg::ADC_MIDPOINT)
                   ? 10'(mds_pkg::ADC_MIDPOINT - {1'b0, adc_reg}) : 10'd0;
    assign ma_full = 18'(offset) * 18'(cfg.current_scale);
    assign w_eff   = (cfg.lowpass_weight > mds_pkg::WEIGHT_FULL)
                   ? mds_pkg::WEIGHT_FULL : cfg.lowpass_weight;
    assign w_inv   = mds_pkg::WEIGHT_FULL - w_eff;
    assign fsum    = pnew_reg + 25'(w_inv) * 25'(fc_reg);
    assign tprod   = 41'(throttle_reg) * 41'(ceil_reg);
    assign recip   = 47'(quot_reg[22:0]) * 47'(mds_pkg::RECIP_K);

    assign run_duty = (big_reg || d_reg > cfg.pwm_top) ? cfg.pwm_top : d_reg;

    always_comb begin
        drive_next = drive_reg;
        duty_next  = duty_reg;
        conv_next  = conv_reg;
        case (drive_reg)
            mds_pkg::ST_RUN: begin
                if (fc_reg > cfg.max_current) begin
                    duty_next  = '0;
                    drive_next = mds_pkg::ST_OVER;
                end else if (battery_reg == '0) begin
                    duty_next  = '0;
                    conv_next  = 1'b0;
                    drive_next = mds_pkg::ST_IDLE;
                end else if (brake_reg != '0 || deadman_reg < mds_pkg::DEADMAN_MIN) begin
                    duty_next = '0;
                end else begin
                    duty_next = run_duty;
                end
            end
            mds_pkg::ST_OVER: begin
                if (restart_reg != '0) begin
                    drive_next = mds_pkg::ST_RUN;
                end else begin
                    if (battery_reg == '0) begin
                        conv_next  = 1'b0;
                        drive_next = mds_pkg::ST_IDLE;
                    end
                    duty_next = '0;
                end
            end
            default: begin
                if (battery_reg == mds_pkg::BATT_START) begin
                    conv_next  = 1'b1;
                    drive_next = mds_pkg::ST_RUN;
                end else begin
                    drive_next = mds_pkg::ST_IDLE;
                    duty_next  = '0;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            drive_reg    <= mds_pkg::ST_IDLE;
            brake_reg    <= '0;
            battery_reg  <= '0;
            throttle_reg <= '0;
            restart_reg  <= '0;
            deadman_reg  <= '0;
            rpm_reg      <= '0;
            fc_reg       <= '0;
            duty_reg     <= '0;
            conv_reg     <= 1'b0;
        end else begin
            if (cmd.accept && !s_func) begin
                if (s_frame_id == mds_pkg::BRAKE_ID) begin
                    brake_reg <= s_data_byte0;
                end else if (s_frame_id == mds_pkg::BATTERY_ID) begin
                    battery_reg <= s_data_byte0;
                end else if (s_frame_id == mds_pkg::STEERING_ID) begin
                    throttle_reg <= s_data_byte3;
                    restart_reg  <= s_data_byte1 & cfg.restart_mask;
                    deadman_reg  <= s_data_byte2;
                end else if (s_frame_id == mds_pkg::ENCODER_ID) begin
                    rpm_reg <= rpm_word;
                end
            end
            if (cmd.calc3 && tick_reg) begin
                fc_reg <= fsum[23:8];
            end
            if (cmd.step) begin
                drive_reg <= drive_next;
                duty_reg  <= duty_next;
                conv_reg  <= conv_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            tick_reg <= s_func;
            adc_reg  <= s_adc_sample;
        end
        if (cmd.calc1) begin
            ma_reg   <= (ma_full > 18'hFFFF) ? 16'hFFFF : ma_full[15:0];
            prod_reg <= 32'(cfg.duty_slope) * 32'(rpm_reg);
        end
        if (cmd.calc2) begin
            pnew_reg <= 25'(w_eff) * 25'(ma_reg);
            ceil_reg <= {15'd0, cfg.duty_base, 8'd0} + {1'b0, prod_reg};
        end
        if (cmd.calc3) begin
            quot_reg <= tprod[40:8];
        end
        if (cmd.calc4) begin
            big_reg <= (quot_reg >= mds_pkg::QUOT_LIMIT);
            d_reg   <= recip[45:30];
        end
        if (cmd.step) begin
            out_state_reg   <= drive_next;
            out_duty_reg    <= duty_next;
            out_conv_reg    <= conv_next;
            out_due_reg     <= tick_reg;
            out_fstatus_reg <= tick_reg ? drive_reg : 2'd0;
            out_fthr_reg    <= tick_reg ? throttle_reg : 8'd0;
            out_fcur_reg    <= tick_reg ? fc_reg : 16'd0;
            out_fduty_reg   <= tick_reg ? duty_reg : 16'd0;
            out_frpm_reg    <= tick_reg ? rpm_reg : 16'd0;
        end
    end

    assign m_state_code     = out_state_reg;
    assign m_led_color      = out_state_reg;
    assign m_duty           = out_duty_reg;
    assign m_dcdc_on        = out_conv_reg;
    assign m_frame_due      = out_due_reg;
    assign m_frame_status   = out_fstatus_reg;
    assign m_frame_throttle = out_fthr_reg;
    assign m_frame_current  = out_fcur_reg;
    assign m_frame_duty     = out_fduty_reg;
    assign m_frame_rpm      = out_frpm_reg;

endmodule

// ===== rtl/motor_drive_supervisor.sv =====
// Motor drive supervisor top level: configuration registers, controller and
// datapath. Depends on mds_pkg, mds_ctrl and mds_datapath.
//
// Each request (a CAN frame or a timer tick with an ADC sample) produces one
// result. The result becomes valid after the control step and s_ready returns
// with it, so a new request is accepted only once the previous one is through: the
// datapath runs a fixed four-phase multiply chain (ADC scaling, low-pass filter,
// duty ceiling, throttle product and the reciprocal divide by 100) before the
// control step. The next request is accepted while the previous result waits;
// if the result is still not taken when the control step is due, the step waits
// for m_ready. Configuration writes are always accepted and should be made while
// idle.
module motor_drive_supervisor (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [mds_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                   cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_func,
    input  logic [10:0]                   s_frame_id,
    input  logic [7:0]                    s_data_byte0,
    input  logic [7:0]                    s_data_byte1,
    input  logic [7:0]                    s_data_byte2,
    input  logic [7:0]                    s_data_byte3,
    input  logic [7:0]                    s_data_byte4,
    input  logic [7:0]                    s_data_byte5,
    input  logic [7:0]                    s_data_byte6,
    input  logic [7:0]                    s_data_byte7,
    input  logic [9:0]                    s_adc_sample,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_state_code,
    output logic [15:0]                   m_duty,
    output logic                          m_dcdc_on,
    output logic [1:0]                    m_led_color,
    output logic                          m_frame_due,
    output logic [1:0]                    m_frame_status,
    output logic [7:0]                    m_frame_throttle,
    output logic [15:0]                   m_frame_current,
    output logic [15:0]                   m_frame_duty,
    output logic [15:0]                   m_frame_rpm
);

    mds_pkg::cfg_t cfg_reg;
    mds_pkg::cmd_t cmd;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_current     <= mds_pkg::RST_MAX_CURRENT;
            cfg_reg.pwm_top         <= mds_pkg::RST_PWM_TOP;
            cfg_reg.duty_base       <= mds_pkg::RST_DUTY_BASE;
            cfg_reg.duty_slope      <= mds_pkg::RST_DUTY_SLOPE;
            cfg_reg.lowpass_weight  <= mds_pkg::RST_LOWPASS_WEIGHT;
            cfg_reg.rpm_word_sel    <= mds_pkg::RST_RPM_WORD_SEL;
            cfg_reg.current_scale   <= mds_pkg::RST_CURRENT_SCALE;
            cfg_reg.restart_mask    <= mds_pkg::RST_RESTART_MASK;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                mds_pkg::CFG_MAX_CURRENT:     cfg_reg.max_current     <= cfg_data;
                mds_pkg::CFG_PWM_TOP:         cfg_reg.pwm_top         <= cfg_data;
                mds_pkg::CFG_DUTY_BASE:       cfg_reg.duty_base       <= cfg_data[9:0];
                mds_pkg::CFG_DUTY_SLOPE:      cfg_reg.duty_slope      <= cfg_data;
                mds_pkg::CFG_LOWPASS_WEIGHT:  cfg_reg.lowpass_weight  <= cfg_data[8:0];
                mds_pkg::CFG_RPM_WORD_SEL:    cfg_reg.rpm_word_sel    <= cfg_data[1:0];
                mds_pkg::CFG_CURRENT_SCALE:   cfg_reg.current_scale   <= cfg_data[7:0];
                mds_pkg::CFG_RESTART_MASK:    cfg_reg.restart_mask    <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    mds_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    mds_datapath u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg              (cfg_reg),
        .cmd              (cmd),
        .s_func           (s_func),
        .s_frame_id       (s_frame_id),
        .s_data_byte0     (s_data_byte0),
        .s_data_byte1     (s_data_byte1),
        .s_data_byte2     (s_data_byte2),
        .s_data_byte3     (s_data_byte3),
        .s_data_byte4     (s_data_byte4),
        .s_data_byte5     (s_data_byte5),
        .s_data_byte6     (s_data_byte6),
        .s_data_byte7     (s_data_byte7),
        .s_adc_sample     (s_adc_sample),
        .m_state_code     (m_state_code),
        .m_duty           (m_duty),
        .m_dcdc_on        (m_dcdc_on),
        .m_led_color      (m_led_color),
        .m_frame_due      (m_frame_due),
        .m_frame_status   (m_frame_status),
        .m_frame_throttle (m_frame_throttle),
        .m_frame_current  (m_frame_current),
        .m_frame_duty     (m_frame_duty),
        .m_frame_rpm      (m_frame_rpm)
    );

    // one request in flight at a time
    a_single_request: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while another is in flight");

    // frame fields are zero on frame requests
    a_frame_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_frame_due |-> m_frame_status == 2'd0 && m_frame_duty == 16'd0
            && m_frame_current == 16'd0 && m_frame_rpm == 16'd0)
        else $error("frame fields set on a frame request");

    // no drive outside the running state
    a_duty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_state_code == mds_pkg::ST_IDLE || m_state_code == mds_pkg::ST_OVER)
            |-> m_duty == 16'd0)
        else $error("nonzero duty while idle or overloaded");

    // converter must be on while running
    a_conv_running: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_state_code == mds_pkg::ST_RUN |-> m_dcdc_on)
        else $error("running with converter off");

endmodule
